[hdl/ahcpr_pkg.sv]
// ----------------------------------------------------------------------------
// ahcpr_pkg
// Shared widths, constants and stage types of the heat/cool power regulator.
// ----------------------------------------------------------------------------
package ahcpr_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned POWER_W   = 8;
  localparam int unsigned PROBE_W   = 4;

  // reciprocal divide: exact for any SUM_W-bit sum and divisor below 2**COUNT_W
  localparam int unsigned DIV_SHIFT = SUM_W + COUNT_W;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  localparam logic [POWER_W-1:0] POWER_MAX   = '1;
  localparam logic [POWER_W-1:0] POWER_STEP  = POWER_W'(1);
  localparam logic [PROBE_W:0]   PROBE_LIMIT = (PROBE_W+1)'(10);

  // completed bucket, from accumulator to divider
  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] sum;
  } bucket_t;

  // bucket average, from divider to regulator
  typedef struct packed {
    logic               vld;
    logic [LEVEL_W-1:0] level;
  } avg_t;

endpackage

[hdl/ahcpr_accum.sv]
// ----------------------------------------------------------------------------
// ahcpr_accum
// Sums accepted samples into buckets and registers each completed bucket sum.
// ----------------------------------------------------------------------------
module ahcpr_accum #(
  parameter int unsigned BUCKET_SIZE = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  logic [ahcpr_pkg::SAMPLE_W-1:0]    adc_sample_i,
  input  logic                              cfg_we_i,
  output ahcpr_pkg::bucket_t                bucket_o
);

  logic [ahcpr_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [ahcpr_pkg::COUNT_W-1:0] count_q, count_inc;
  logic                          take, full;
  logic                          bkt_vld_q;
  logic [ahcpr_pkg::SUM_W-1:0]   bkt_sum_q;

  assign take      = in_valid_i & en_i;
  assign sum_d     = sum_q + ahcpr_pkg::SUM_W'(adc_sample_i);
  assign count_inc = count_q + ahcpr_pkg::COUNT_W'(1);
  assign full      = (count_inc == ahcpr_pkg::COUNT_W'(BUCKET_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (take) begin
      if (full) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_vld_q <= 1'b0;
    end else if (en_i) begin
      bkt_vld_q <= take & full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && take && full) begin
      bkt_sum_q <= sum_d;
    end
  end

  assign bucket_o.vld = bkt_vld_q;
  assign bucket_o.sum = bkt_sum_q;

endmodule

[hdl/ahcpr_avg.sv]
// ----------------------------------------------------------------------------
// ahcpr_avg
// Bucket average by multiplication with a rounded-up reciprocal of the size.
// ----------------------------------------------------------------------------
module ahcpr_avg #(
  parameter int unsigned BUCKET_SIZE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ahcpr_pkg::bucket_t bucket_i,
  output ahcpr_pkg::avg_t    avg_o
);

  localparam longint unsigned RECIP_FULL =
    ((64'd1 << ahcpr_pkg::DIV_SHIFT) + 64'(BUCKET_SIZE) - 64'd1) / 64'(BUCKET_SIZE);
  localparam logic [ahcpr_pkg::RECIP_W-1:0] RECIP = ahcpr_pkg::RECIP_W'(RECIP_FULL);

  logic [ahcpr_pkg::PROD_W-1:0]  prod;
  logic                          vld_q;
  logic [ahcpr_pkg::LEVEL_W-1:0] level_q;

  assign prod = ahcpr_pkg::PROD_W'(bucket_i.sum) * ahcpr_pkg::PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= bucket_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && bucket_i.vld) begin
      level_q <= prod[ahcpr_pkg::DIV_SHIFT +: ahcpr_pkg::LEVEL_W];
    end
  end

  assign avg_o.vld   = vld_q;
  assign avg_o.level = level_q;

endmodule

[hdl/ahcpr_ctrl.sv]
// ----------------------------------------------------------------------------
// ahcpr_ctrl
// Regulator state: target crossing, heat/cool power adaptation, result register.
// ----------------------------------------------------------------------------
module ahcpr_ctrl #(
  parameter int unsigned HEAT_PERIOD = 100
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ahcpr_pkg::avg_t                 avg_i,
  input  logic                            cfg_we_i,
  input  logic [ahcpr_pkg::LEVEL_W-1:0]   target_level_i,
  output logic                            out_valid_o,
  output logic [ahcpr_pkg::POWER_W-1:0]   drive_power_o,
  output logic [ahcpr_pkg::LEVEL_W-1:0]   average_level_o,
  output logic                            target_reached_o,
  output logic                            heater_stable_o
);

  localparam logic [ahcpr_pkg::POWER_W-1:0] HEAT_RST = ahcpr_pkg::POWER_W'(HEAT_PERIOD);

  logic [ahcpr_pkg::LEVEL_W-1:0] target_q, cur_q, start_q;
  logic [ahcpr_pkg::POWER_W-1:0] heat_q, heat_d, floor_q, floor_d;
  logic [ahcpr_pkg::POWER_W-1:0] cool_q, cool_d, ceil_q, ceil_d;
  logic [ahcpr_pkg::PROBE_W-1:0] probe_q;
  logic [ahcpr_pkg::PROBE_W:0]   probe_d;
  logic                          heating_q, heating_d;
  logic                          reached_q, reached_d;
  logic [ahcpr_pkg::LEVEL_W-1:0] avg, st;
  logic                          below, st_below, fall, rise;
  logic [ahcpr_pkg::POWER_W-1:0] power;
  logic                          stable;
  logic                          step;

  logic                          out_vld_q;
  logic [ahcpr_pkg::POWER_W-1:0] power_q;
  logic [ahcpr_pkg::LEVEL_W-1:0] level_q;
  logic                          reached_out_q, stable_q;

  assign step = en_i & avg_i.vld;

  always_comb begin
    avg       = avg_i.level;
    // a zero start level counts as unset
    st        = (start_q == '0) ? avg : start_q;
    below     = avg < target_q;
    st_below  = st < target_q;
    fall      = avg <= cur_q;
    rise      = avg >= cur_q;
    reached_d = reached_q | (avg == target_q) | (st == target_q) | (below != st_below);

    heat_d    = heat_q;
    floor_d   = floor_q;
    cool_d    = cool_q;
    ceil_d    = ceil_q;
    heating_d = heating_q;
    probe_d   = {1'b0, probe_q};

    if (below) begin
      power = heat_q;
      if (heating_q) begin
        if (fall && heat_q == floor_q) begin
          if (probe_q != '0) begin
            probe_d = '0;
            heat_d  = (floor_q == ahcpr_pkg::POWER_MAX) ? ahcpr_pkg::POWER_MAX
                                                        : floor_q + ahcpr_pkg::POWER_STEP;
          end else begin
            probe_d = {1'b0, probe_q} + (ahcpr_pkg::PROBE_W+1)'(2);
          end
        end else if (fall) begin
          probe_d = {1'b0, probe_q} + (ahcpr_pkg::PROBE_W+1)'(1);
        end
      end else begin
        if (reached_d && cool_q < heat_q && ceil_q == cool_q) begin
          ceil_d = ceil_q + ahcpr_pkg::POWER_W'(1);
          cool_d = cool_q + ahcpr_pkg::POWER_W'(1);
        end
        probe_d   = '0;
        heating_d = 1'b1;
      end
    end else begin
      power = cool_q;
      if (!heating_q) begin
        if (rise && ceil_q > ahcpr_pkg::POWER_STEP && cool_q == ceil_q) begin
          // step back clears the count, then the flat/rising count adds one
          if (probe_q != '0) begin
            probe_d = (ahcpr_pkg::PROBE_W+1)'(1);
            cool_d  = ceil_q - ahcpr_pkg::POWER_STEP;
          end else begin
            probe_d = (ahcpr_pkg::PROBE_W+1)'(2);
          end
        end else if (rise) begin
          probe_d = {1'b0, probe_q} + (ahcpr_pkg::PROBE_W+1)'(1);
        end
      end else begin
        if (reached_d && cool_q < heat_q && floor_q == heat_q) begin
          heat_d  = heat_q - ahcpr_pkg::POWER_W'(1);
          floor_d = floor_q - ahcpr_pkg::POWER_W'(1);
        end
        probe_d   = '0;
        heating_d = 1'b0;
      end
    end

    if (probe_d > ahcpr_pkg::PROBE_LIMIT) begin
      heat_d  = HEAT_RST;
      floor_d = HEAT_RST;
      cool_d  = '0;
      ceil_d  = '0;
      probe_d = '0;
    end

    stable = (heat_d > floor_d) && (ceil_d > cool_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      cur_q     <= '0;
      start_q   <= '0;
      heat_q    <= HEAT_RST;
      floor_q   <= HEAT_RST;
      cool_q    <= '0;
      ceil_q    <= '0;
      probe_q   <= '0;
      heating_q <= 1'b0;
      reached_q <= 1'b0;
    end else if (cfg_we_i) begin
      // re-arm; heating direction is kept
      target_q  <= target_level_i;
      start_q   <= cur_q;
      reached_q <= 1'b0;
      heat_q    <= HEAT_RST;
      floor_q   <= HEAT_RST;
      cool_q    <= '0;
      ceil_q    <= '0;
      probe_q   <= '0;
    end else if (step) begin
      cur_q     <= avg;
      start_q   <= st;
      reached_q <= reached_d;
      heat_q    <= heat_d;
      floor_q   <= floor_d;
      cool_q    <= cool_d;
      ceil_q    <= ceil_d;
      probe_q   <= probe_d[ahcpr_pkg::PROBE_W-1:0];
      heating_q <= heating_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= avg_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      power_q       <= power;
      level_q       <= avg;
      reached_out_q <= reached_d;
      stable_q      <= stable;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign drive_power_o    = power_q;
  assign average_level_o  = level_q;
  assign target_reached_o = reached_out_q;
  assign heater_stable_o  = stable_q;

endmodule

[hdl/adaptive_heat_cool_power_regulator.sv]
// ----------------------------------------------------------------------------
// adaptive_heat_cool_power_regulator
// Bucket-averaging temperature regulator with adaptive heat and cool power.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, adc_sample_i) takes one raw sample
//   per transfer. Every BUCKET_SIZE samples one result is produced on the
//   output channel (out_valid_o/out_ready_i): drive power, bucket average,
//   target-reached flag and stability flag. Other samples give no result.
//   out_valid_o rises for a bucket-completing sample after it passes the
//   registers in order: accumulate register loads at the transfer, then
//   reciprocal multiply, then regulator update.
//   Throughput: one sample per cycle while the receiver does not stall; the three stages each hold one item.
//   A stalled receiver freezes all three stages together and drops
//   in_ready_o, so in_ready_o = !out_valid_o || out_ready_i.
//   cfg_we_i writes target_level_i and re-arms the regulator; write only when
//   the block is idle.
//   Reset clears the bucket, levels and flags; powers return to HEAT_PERIOD
//   for heat and zero for cool. No clearing pass is needed.
// ----------------------------------------------------------------------------
module adaptive_heat_cool_power_regulator #(
  parameter int unsigned HEAT_PERIOD = 100,
  parameter int unsigned BUCKET_SIZE = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ahcpr_pkg::SAMPLE_W-1:0]  adc_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ahcpr_pkg::POWER_W-1:0]   drive_power_o,
  output logic [ahcpr_pkg::LEVEL_W-1:0]   average_level_o,
  output logic                            target_reached_o,
  output logic                            heater_stable_o,
  input  logic                            cfg_we_i,
  input  logic [ahcpr_pkg::LEVEL_W-1:0]   target_level_i
);

  logic               en;
  ahcpr_pkg::bucket_t bucket;
  ahcpr_pkg::avg_t    avg;

  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  ahcpr_accum #(
    .BUCKET_SIZE(BUCKET_SIZE)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .adc_sample_i(adc_sample_i),
    .cfg_we_i    (cfg_we_i),
    .bucket_o    (bucket)
  );

  ahcpr_avg #(
    .BUCKET_SIZE(BUCKET_SIZE)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .bucket_i(bucket),
    .avg_o   (avg)
  );

  ahcpr_ctrl #(
    .HEAT_PERIOD(HEAT_PERIOD)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .avg_i           (avg),
    .cfg_we_i        (cfg_we_i),
    .target_level_i  (target_level_i),
    .out_valid_o     (out_valid_o),
    .drive_power_o   (drive_power_o),
    .average_level_o (average_level_o),
    .target_reached_o(target_reached_o),
    .heater_stable_o (heater_stable_o)
  );

endmodule

[hdl/ahcpr_checker.sv]
// ----------------------------------------------------------------------------
// ahcpr_checker
// Port-level assertions for the heat/cool power regulator, bound to the top.
// ----------------------------------------------------------------------------
module ahcpr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [ahcpr_pkg::SAMPLE_W-1:0]  adc_sample_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [ahcpr_pkg::POWER_W-1:0]   drive_power_o,
  input logic [ahcpr_pkg::LEVEL_W-1:0]   average_level_o,
  input logic                            target_reached_o,
  input logic                            heater_stable_o,
  input logic                            cfg_we_i,
  input logic [ahcpr_pkg::LEVEL_W-1:0]   target_level_i
);

  logic [ahcpr_pkg::LEVEL_W-1:0] tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
    end else if (cfg_we_i) begin
      tgt_q <= target_level_i;
    end
  end

  // a waiting input transfer keeps its sample
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(adc_sample_i))
    else $error("input sample changed while waiting");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_power_o)
      && $stable(average_level_o) && $stable(target_reached_o)
      && $stable(heater_stable_o))
    else $error("result changed while stalled");

  // input side stalls only behind a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // an average equal to the target always counts as reached
  a_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && average_level_o == tgt_q |-> target_reached_o)
    else $error("target hit but not flagged");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without transfer");

endmodule

bind adaptive_heat_cool_power_regulator ahcpr_checker u_checker (.*);
